### sv/repeated_key_detector_macros.svh
// Assertion macros shared by the repeated-key detector RTL.
`ifndef REPEATED_KEY_DETECTOR_MACROS_SVH
`define REPEATED_KEY_DETECTOR_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define RKD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("repeated_key_detector: same-cycle check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define RKD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("repeated_key_detector: next-cycle check failed");

`endif

### sv/rkd_pkg.sv
// Shared constants for the repeated-key detector.
package rkd_pkg;

   localparam int TableDepth = 256;
   localparam int IdxWidth   = $clog2(TableDepth);
   localparam int CntWidth   = IdxWidth + 1;
   localparam int KeyWidth   = 64;
   localparam int OccWidth   = 2;

   localparam logic [OccWidth-1:0] TripleCount = OccWidth'(3);

   // operation codes of an input item
   localparam logic OpStart  = 1'b0;
   localparam logic OpInsert = 1'b1;

endpackage

### sv/rkd_if.sv
// Handshake channels of the repeated-key detector: request and response.
interface rkd_req_if;
   logic                                valid;
   logic                                ready;
   logic                                operation;
   logic signed [rkd_pkg::KeyWidth-1:0] key;

   modport source (output valid, output operation, output key, input ready);
   modport sink   (input valid, input operation, input key, output ready);
endinterface

interface rkd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          triple_found;
   logic [rkd_pkg::OccWidth-1:0]  key_occurrences;
   logic                          table_full;

   modport source (output valid, output triple_found, output key_occurrences,
                   output table_full, input ready);
   modport sink   (input valid, input triple_found, input key_occurrences,
                   input table_full, output ready);
endinterface

### sv/rkd_key_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module rkd_key_ram #(
   parameter int Depth = 256,
   parameter int Width = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### sv/repeated_key_detector.sv
// Repeated-key detector top level: sorted key table, controller and response register.
//
// Keeps up to rkd_pkg::TableDepth 64-bit keys in ascending unsigned order in one
// RAM. A start item (operation 0) clears the table to its key alone and goes
// through the wait state to the response. An insert walks the table from the
// top entry down, one entry per cycle on the single RAM read port, moving each
// larger key up one slot, writes the new key, then keeps reading down while it
// meets equal keys, until the count saturates or the bottom entry is read. An
// insert into an empty table writes its key alone. A stalled response holds the
// detector in its wait state. key_occurrences saturates at 3 and triple_found
// stays set until the next start item. An insert into a full table leaves it
// unchanged, reports table_full and counts the stored copies. The response sits
// in an output register, so a new item is taken while the previous response
// waits. No clearing pass is needed after reset.
`include "repeated_key_detector_macros.svh"

module repeated_key_detector (
   input  logic      clock,
   input  logic      reset,
   rkd_req_if.sink   req_chan,
   rkd_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PLACE0,
      ST_WAIT
   } state_type;

   state_type                      state_ff, state_in;
   logic [rkd_pkg::CntWidth-1:0]   count_ff, count_in;
   logic                           triple_ff, triple_in;
   logic [rkd_pkg::KeyWidth-1:0]   key_ff, key_in;
   logic                           full_ff, full_in;
   logic                           placed_ff, placed_in;
   logic [rkd_pkg::OccWidth-1:0]   occ_ff, occ_in;
   logic [rkd_pkg::IdxWidth-1:0]   addr_ff, addr_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_triple_ff, rsp_triple_in;
   logic [rkd_pkg::OccWidth-1:0]   rsp_occ_ff, rsp_occ_in;
   logic                           rsp_full_ff, rsp_full_in;

   logic                           ram_we;
   logic [rkd_pkg::IdxWidth-1:0]   ram_waddr;
   logic [rkd_pkg::KeyWidth-1:0]   ram_wdata;
   logic [rkd_pkg::IdxWidth-1:0]   ram_raddr;
   logic [rkd_pkg::KeyWidth-1:0]   ram_rdata;

   logic                           data_gt;
   logic                           data_eq;
   logic                           triple_next;

   rkd_key_ram #(
      .Depth (rkd_pkg::TableDepth),
      .Width (rkd_pkg::KeyWidth)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign data_gt     = ram_rdata > key_ff;
   assign data_eq     = ram_rdata == key_ff;
   assign triple_next = triple_ff | (occ_ff == rkd_pkg::TripleCount);

   assign req_chan.ready           = state_ff == ST_IDLE;
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.triple_found    = rsp_triple_ff;
   assign rsp_chan.key_occurrences = rsp_occ_ff;
   assign rsp_chan.table_full      = rsp_full_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      triple_in     = triple_ff;
      key_in        = key_ff;
      full_in       = full_ff;
      placed_in     = placed_ff;
      occ_in        = occ_ff;
      addr_in       = addr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_triple_in = rsp_triple_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_full_in   = rsp_full_ff;
      ram_we        = 1'b0;
      ram_waddr     = addr_ff + rkd_pkg::IdxWidth'(1);
      ram_wdata     = key_ff;
      // read one entry ahead; a wasted read at the bottom is harmless
      ram_raddr     = addr_ff - rkd_pkg::IdxWidth'(1);

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               key_in    = $unsigned(req_chan.key);
               placed_in = 1'b0;
               if (req_chan.operation == rkd_pkg::OpStart) begin
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = $unsigned(req_chan.key);
                  count_in  = rkd_pkg::CntWidth'(1);
                  triple_in = 1'b0;
                  occ_in    = rkd_pkg::OccWidth'(1);
                  full_in   = 1'b0;
                  state_in  = ST_WAIT;
               end else if (count_ff == '0) begin
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = $unsigned(req_chan.key);
                  count_in  = rkd_pkg::CntWidth'(1);
                  occ_in    = rkd_pkg::OccWidth'(1);
                  full_in   = 1'b0;
                  state_in  = ST_WAIT;
               end else begin
                  full_in   = count_ff == rkd_pkg::CntWidth'(rkd_pkg::TableDepth);
                  occ_in    = full_in ? '0 : rkd_pkg::OccWidth'(1);
                  addr_in   = rkd_pkg::IdxWidth'(count_ff - rkd_pkg::CntWidth'(1));
                  ram_raddr = addr_in;
                  if (!full_in) begin
                     count_in = count_ff + rkd_pkg::CntWidth'(1);
                  end
                  state_in  = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (!placed_ff && data_gt) begin
               // shift the larger key up one slot
               if (!full_ff) begin
                  ram_we    = 1'b1;
                  ram_wdata = ram_rdata;
               end
               if (addr_ff == '0) begin
                  state_in = full_ff ? ST_WAIT : ST_PLACE0;
               end else begin
                  addr_in = addr_ff - rkd_pkg::IdxWidth'(1);
               end
            end else begin
               if (!placed_ff && !full_ff) begin
                  ram_we = 1'b1;
               end
               placed_in = 1'b1;
               if (data_eq) begin
                  occ_in = occ_ff + rkd_pkg::OccWidth'(1);
                  if (occ_in == rkd_pkg::TripleCount || addr_ff == '0) begin
                     state_in = ST_WAIT;
                  end else begin
                     addr_in = addr_ff - rkd_pkg::IdxWidth'(1);
                  end
               end else begin
                  state_in = ST_WAIT;
               end
            end
         end

         ST_PLACE0: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            state_in  = ST_WAIT;
         end

         ST_WAIT: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_triple_in = triple_next;
               rsp_occ_in    = occ_ff;
               rsp_full_in   = full_ff;
               triple_in     = triple_next;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         triple_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         triple_ff    <= triple_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff        <= key_in;
      full_ff       <= full_in;
      placed_ff     <= placed_in;
      occ_ff        <= occ_in;
      addr_ff       <= addr_in;
      rsp_triple_ff <= rsp_triple_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_full_ff   <= rsp_full_in;
   end

   `RKD_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= rkd_pkg::CntWidth'(rkd_pkg::TableDepth))
   `RKD_ASSERT_NOW(a_scan_write_in_table, (state_ff == ST_SCAN) && ram_we, rkd_pkg::CntWidth'(ram_waddr) < count_ff)
   `RKD_ASSERT_NEXT(a_start_loads_one, req_chan.valid && req_chan.ready && (req_chan.operation == rkd_pkg::OpStart), (count_ff == rkd_pkg::CntWidth'(1)) && !triple_ff)
   `RKD_ASSERT_NOW(a_triple_reported, rsp_valid_ff && (rsp_occ_ff == rkd_pkg::TripleCount), rsp_triple_ff)
   `RKD_ASSERT_NOW(a_zero_only_when_full, rsp_valid_ff && (rsp_occ_ff == '0), rsp_full_ff)

endmodule
